// ===== hw/rtl/rhc_pkg.sv =====
// ----------------------------------------------------------------------------
// rhc_pkg
// Shared types, constants and helpers for the RGB/HSV color converter.
// ----------------------------------------------------------------------------
package rhc_pkg;

   localparam int PIPE_STAGES = 7;

   localparam logic [7:0] FULL_SCALE     = 8'd255;
   localparam logic [7:0] HUE_SECTOR     = 8'd43;
   localparam logic [7:0] HUE_BASE_RED   = 8'd0;
   localparam logic [7:0] HUE_BASE_GREEN = 8'd85;
   localparam logic [7:0] HUE_BASE_BLUE  = 8'd171;
   localparam logic [7:0] REM_SCALE      = 8'd6;

   localparam logic DIR_RGB_TO_HSV = 1'b0;
   localparam logic DIR_HSV_TO_RGB = 1'b1;

   typedef struct packed {
      logic [7:0] channel_a;
      logic [7:0] channel_b;
      logic [7:0] channel_c;
   } req_word_type;

   typedef struct packed {
      logic [7:0] result_a;
      logic [7:0] result_b;
      logic [7:0] result_c;
   } rsp_word_type;

   typedef struct packed {
      logic valid;
      logic mode;
   } pipe_tail_type;

   // one restoring division step: returns {quotient bit, new remainder}
   function automatic logic [8:0] div_bit(input logic [7:0] rem,
                                          input logic       next_bit,
                                          input logic [7:0] divisor);
      logic [8:0] trial;
      logic [8:0] diff;
      trial = {rem, next_bit};
      diff  = trial - {1'b0, divisor};
      if (trial >= {1'b0, divisor}) begin
         return {1'b1, diff[7:0]};
      end else begin
         return {1'b0, trial[7:0]};
      end
   endfunction

endpackage

// ===== hw/rtl/rhc_pipe_ctrl.sv =====
// ----------------------------------------------------------------------------
// rhc_pipe_ctrl
// Valid and mode bits for every stage, with per-stage load enables so that
// bubbles collapse and a stall at the output loses or repeats nothing.
// ----------------------------------------------------------------------------
module rhc_pipe_ctrl (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                rsp_stall,
   input  logic                                mode,
   output logic [rhc_pkg::PIPE_STAGES-1:0]     stage_en,
   output rhc_pkg::pipe_tail_type              tail
);
   import rhc_pkg::*;

   logic [PIPE_STAGES-1:0] valid_ff;
   logic [PIPE_STAGES-1:0] valid_in;
   logic [PIPE_STAGES-1:0] mode_ff;
   logic [PIPE_STAGES-1:0] mode_in;
   logic [PIPE_STAGES-1:0] ready;

   always_comb begin
      ready[PIPE_STAGES-1] = !valid_ff[PIPE_STAGES-1] || !rsp_stall;
      for (int i = PIPE_STAGES - 2; i >= 0; i--) begin
         ready[i] = !valid_ff[i] || ready[i+1];
      end
   end

   always_comb begin
      valid_in = valid_ff;
      mode_in  = mode_ff;
      if (ready[0]) begin
         valid_in[0] = req_valid;
         mode_in[0]  = mode;
      end
      for (int i = 1; i < PIPE_STAGES; i++) begin
         if (ready[i]) begin
            valid_in[i] = valid_ff[i-1];
            mode_in[i]  = mode_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
      mode_ff <= mode_in;
   end

   assign stage_en   = ready;
   assign tail.valid = valid_ff[PIPE_STAGES-1];
   assign tail.mode  = mode_ff[PIPE_STAGES-1];

endmodule

// ===== hw/rtl/rhc_fwd_path.sv =====
// ----------------------------------------------------------------------------
// rhc_fwd_path
// RGB to HSV datapath: min/max, scaling products, two pipelined 2-bit-per-
// stage dividers for saturation and hue offset, then hue assembly.
// ----------------------------------------------------------------------------
module rhc_fwd_path (
   input  logic                            clock,
   input  logic [rhc_pkg::PIPE_STAGES-1:0] stage_en,
   input  rhc_pkg::req_word_type           in_word,
   output rhc_pkg::rsp_word_type           out_word
);
   import rhc_pkg::*;

   localparam int DIV_STAGES = 4;

   typedef struct packed {
      logic [7:0] s_rem;
      logic [7:0] s_quo;
      logic [7:0] s_low;
      logic [7:0] h_rem;
      logic [7:0] h_quo;
      logic [7:0] h_low;
      logic [7:0] vmax;
      logic [7:0] delta;
      logic       neg;
      logic [7:0] base;
   } div_state_type;

   // stage 1: extremes and hue difference
   logic [7:0] vmax_ff, vmax_in, delta_ff, delta_in, adiff_ff, adiff_in, base_ff, base_in;
   logic       neg_ff, neg_in;

   always_comb begin
      logic [7:0] r, g, b, vmin, pos, sub;
      r = in_word.channel_a;
      g = in_word.channel_b;
      b = in_word.channel_c;
      if (r >= g && r >= b) begin
         vmax_in = r;
         base_in = HUE_BASE_RED;
         pos     = g;
         sub     = b;
      end else if (g >= b) begin
         vmax_in = g;
         base_in = HUE_BASE_GREEN;
         pos     = b;
         sub     = r;
      end else begin
         vmax_in = b;
         base_in = HUE_BASE_BLUE;
         pos     = r;
         sub     = g;
      end
      vmin = (r <= g) ? r : g;
      if (b < vmin) begin
         vmin = b;
      end
      delta_in = vmax_in - vmin;
      neg_in   = pos < sub;
      adiff_in = neg_in ? (sub - pos) : (pos - sub);
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         vmax_ff  <= vmax_in;
         delta_ff <= delta_in;
         adiff_ff <= adiff_in;
         base_ff  <= base_in;
         neg_ff   <= neg_in;
      end
   end

   // stage 2: dividends
   logic [15:0] s_num_ff, s_num_in, h_num_ff, h_num_in;
   logic [7:0]  vmax2_ff, delta2_ff, base2_ff;
   logic        neg2_ff;

   assign s_num_in = {delta_ff, 8'd0} - {8'd0, delta_ff};
   assign h_num_in = {8'd0, adiff_ff} * {8'd0, HUE_SECTOR};

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         s_num_ff  <= s_num_in;
         h_num_ff  <= h_num_in;
         vmax2_ff  <= vmax_ff;
         delta2_ff <= delta_ff;
         base2_ff  <= base_ff;
         neg2_ff   <= neg_ff;
      end
   end

   // stages 3 to 6: division, two quotient bits per stage
   div_state_type div_src [DIV_STAGES+1];
   div_state_type div_ff  [DIV_STAGES];

   assign div_src[0] = {s_num_ff[15:8], 8'd0, s_num_ff[7:0],
                        h_num_ff[15:8], 8'd0, h_num_ff[7:0],
                        vmax2_ff, delta2_ff, neg2_ff, base2_ff};

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
      div_state_type step_in;

      always_comb begin
         logic [8:0] s1, s2, h1, h2;
         s1 = div_bit(div_src[k].s_rem, div_src[k].s_low[7], div_src[k].vmax);
         s2 = div_bit(s1[7:0], div_src[k].s_low[6], div_src[k].vmax);
         h1 = div_bit(div_src[k].h_rem, div_src[k].h_low[7], div_src[k].delta);
         h2 = div_bit(h1[7:0], div_src[k].h_low[6], div_src[k].delta);
         step_in       = div_src[k];
         step_in.s_rem = s2[7:0];
         step_in.s_quo = {div_src[k].s_quo[5:0], s1[8], s2[8]};
         step_in.s_low = {div_src[k].s_low[5:0], 2'b00};
         step_in.h_rem = h2[7:0];
         step_in.h_quo = {div_src[k].h_quo[5:0], h1[8], h2[8]};
         step_in.h_low = {div_src[k].h_low[5:0], 2'b00};
      end

      always_ff @(posedge clock) begin
         if (stage_en[2+k]) begin
            div_ff[k] <= step_in;
         end
      end

      assign div_src[k+1] = div_ff[k];
   end

   // stage 7: hue assembly, grey and black
   rsp_word_type out_ff, out_in;

   always_comb begin
      div_state_type fin;
      logic [7:0]    offset;
      fin    = div_src[DIV_STAGES];
      offset = fin.neg ? (8'd0 - fin.h_quo) : fin.h_quo;
      out_in.result_c = fin.vmax;
      if (fin.delta == 8'd0) begin
         out_in.result_a = '0;
         out_in.result_b = '0;
      end else begin
         out_in.result_a = fin.base + offset;
         out_in.result_b = fin.s_quo;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[PIPE_STAGES-1]) begin
         out_ff <= out_in;
      end
   end

   assign out_word = out_ff;

endmodule

// ===== hw/rtl/rhc_rev_path.sv =====
// ----------------------------------------------------------------------------
// rhc_rev_path
// HSV to RGB datapath: region, remainder and p, then q/t products over
// two multiply stages, region select, then delay to match the forward path.
// ----------------------------------------------------------------------------
module rhc_rev_path (
   input  logic                            clock,
   input  logic [rhc_pkg::PIPE_STAGES-1:0] stage_en,
   input  rhc_pkg::req_word_type           in_word,
   output rhc_pkg::rsp_word_type           out_word
);
   import rhc_pkg::*;

   localparam int WORK_STAGES = 4;

   // stage 1: region, remainder, p
   logic [2:0] region_ff, region_in;
   logic [7:0] rem_ff, rem_in, sat_ff, val_ff, p_ff;
   logic       grey_ff;
   logic [15:0] p_prod;

   always_comb begin
      logic [7:0] h, hoff, hrem;
      h = in_word.channel_a;
      if (h >= 8'd215) begin
         region_in = 3'd5;
      end else if (h >= 8'd172) begin
         region_in = 3'd4;
      end else if (h >= 8'd129) begin
         region_in = 3'd3;
      end else if (h >= 8'd86) begin
         region_in = 3'd2;
      end else if (h >= HUE_SECTOR) begin
         region_in = 3'd1;
      end else begin
         region_in = 3'd0;
      end
      hoff   = 8'({5'd0, region_in} * HUE_SECTOR);
      hrem   = h - hoff;
      rem_in = 8'(hrem * REM_SCALE);
   end

   assign p_prod = {8'd0, in_word.channel_c} * {8'd0, FULL_SCALE - in_word.channel_b};

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         region_ff <= region_in;
         rem_ff    <= rem_in;
         sat_ff    <= in_word.channel_b;
         val_ff    <= in_word.channel_c;
         p_ff      <= p_prod[15:8];
         grey_ff   <= in_word.channel_b == 8'd0;
      end
   end

   // stage 2: saturation times remainder
   logic [15:0] sq_prod, st_prod;
   logic [7:0]  kq_ff, kt_ff, val2_ff, p2_ff;
   logic [2:0]  region2_ff;
   logic        grey2_ff;

   assign sq_prod = {8'd0, sat_ff} * {8'd0, rem_ff};
   assign st_prod = {8'd0, sat_ff} * {8'd0, FULL_SCALE - rem_ff};

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         kq_ff      <= FULL_SCALE - sq_prod[15:8];
         kt_ff      <= FULL_SCALE - st_prod[15:8];
         val2_ff    <= val_ff;
         p2_ff      <= p_ff;
         region2_ff <= region_ff;
         grey2_ff   <= grey_ff;
      end
   end

   // stage 3: q and t
   logic [15:0] q_prod, t_prod;
   logic [7:0]  q3_ff, t3_ff, val3_ff, p3_ff;
   logic [2:0]  region3_ff;
   logic        grey3_ff;

   assign q_prod = {8'd0, val2_ff} * {8'd0, kq_ff};
   assign t_prod = {8'd0, val2_ff} * {8'd0, kt_ff};

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         q3_ff      <= q_prod[15:8];
         t3_ff      <= t_prod[15:8];
         val3_ff    <= val2_ff;
         p3_ff      <= p2_ff;
         region3_ff <= region2_ff;
         grey3_ff   <= grey2_ff;
      end
   end

   // stage 4: region select
   rsp_word_type sel_in;
   rsp_word_type dly_src [PIPE_STAGES-WORK_STAGES+1];
   rsp_word_type dly_ff  [PIPE_STAGES-WORK_STAGES+1];

   always_comb begin
      if (grey3_ff) begin
         sel_in = '{val3_ff, val3_ff, val3_ff};
      end else begin
         case (region3_ff)
            3'd0:    sel_in = '{val3_ff, t3_ff, p3_ff};
            3'd1:    sel_in = '{q3_ff, val3_ff, p3_ff};
            3'd2:    sel_in = '{p3_ff, val3_ff, t3_ff};
            3'd3:    sel_in = '{p3_ff, q3_ff, val3_ff};
            3'd4:    sel_in = '{t3_ff, p3_ff, val3_ff};
            default: sel_in = '{val3_ff, p3_ff, q3_ff};
         endcase
      end
   end

   assign dly_src[0] = sel_in;

   // select register plus delay stages up to the common output stage
   for (genvar k = 0; k <= PIPE_STAGES - WORK_STAGES; k++) begin : g_dly
      always_ff @(posedge clock) begin
         if (stage_en[WORK_STAGES-1+k]) begin
            dly_ff[k] <= dly_src[k];
         end
      end
      if (k < PIPE_STAGES - WORK_STAGES) begin : g_link
         assign dly_src[k+1] = dly_ff[k];
      end
   end

   assign out_word = dly_ff[PIPE_STAGES-WORK_STAGES];

endmodule

// ===== hw/rtl/rgb_hsv_color_convert_top.sv =====
// ----------------------------------------------------------------------------
// rgb_hsv_color_convert_top
// Pixel converter between RGB and HSV, 8 bits per channel.
// ----------------------------------------------------------------------------
// Usage:
//   req_word carries one pixel (channel_a/b/c), rsp_word one converted pixel
//   (result_a/b/c). A word moves when valid is high and stall is low.
//   csr_write_enable/csr_write_data set the direction bit: 0 = RGB to HSV,
//   1 = HSV to RGB. Change it only with the pipeline empty; each word picks
//   up the direction at entry.
//   Throughput is one pixel per cycle while req_stall is low, set by a
//   7-stage pipeline whose longest part is the saturation and hue divider,
//   two quotient bits per stage over four stages.
//   When rsp_stall is high, the last stage holds and earlier stages keep
//   filling empty slots; req_stall rises only once every stage is full.
//   Reset clears all valid bits and sets the direction to RGB to HSV.
// ----------------------------------------------------------------------------
module rgb_hsv_color_convert_top (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic                  csr_write_data,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  rhc_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rhc_pkg::rsp_word_type rsp_word
);
   import rhc_pkg::*;

   logic                   dir_ff, dir_in;
   logic [PIPE_STAGES-1:0] stage_en;
   pipe_tail_type          tail;
   rsp_word_type           fwd_word, rev_word;

   assign dir_in = csr_write_enable ? csr_write_data : dir_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff <= DIR_RGB_TO_HSV;
      end else begin
         dir_ff <= dir_in;
      end
   end

   rhc_pipe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .rsp_stall (rsp_stall),
      .mode      (dir_ff),
      .stage_en  (stage_en),
      .tail      (tail)
   );

   rhc_fwd_path u_fwd (
      .clock    (clock),
      .stage_en (stage_en),
      .in_word  (req_word),
      .out_word (fwd_word)
   );

   rhc_rev_path u_rev (
      .clock    (clock),
      .stage_en (stage_en),
      .in_word  (req_word),
      .out_word (rev_word)
   );

   assign req_stall = !stage_en[0];
   assign rsp_valid = tail.valid;
   assign rsp_word  = (tail.mode == DIR_HSV_TO_RGB) ? rev_word : fwd_word;

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Testbench for rgb_hsv_color_convert_top. Directed and random pixels are
// sent in both conversion directions while both handshakes idle at random.
// Every output word is checked field by field against the expected pixel
// from a local conversion function.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import rhc_pkg::*;

   logic         clock;
   logic         reset;
   logic         csr_write_enable;
   logic         csr_write_data;
   logic         req_valid;
   logic         req_stall;
   req_word_type req_word;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_word_type rsp_word;

   rsp_word_type expected_pixels[$];
   rsp_word_type want_pixel;
   logic         active_direction;
   logic         idle_enable;
   int           mismatch_count;
   int           checked_count;

   rgb_hsv_color_convert_top dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_word         (req_word),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_word         (rsp_word)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("** rgb_hsv_color_convert_top: FAILED **");
      $finish;
   end

   function automatic rsp_word_type converted_pixel(input logic mode,
                                                    input req_word_type px);
      rsp_word_type o;
      int a, b, c, hi, lo, span, sat, base, diff, hue;
      int region, rem, p, q, t;
      a = px.channel_a;
      b = px.channel_b;
      c = px.channel_c;
      if (mode == DIR_RGB_TO_HSV) begin
         hi = (a > b) ? a : b;
         lo = (a < b) ? a : b;
         if (c > hi) hi = c;
         if (c < lo) lo = c;
         o.result_a = 8'd0;
         o.result_b = 8'd0;
         o.result_c = hi[7:0];
         if (hi != 0) begin
            span = hi - lo;
            sat = (255 * span) / hi;
            if (sat != 0) begin
               if (hi == a) begin
                  base = 0;
                  diff = b - c;
               end else if (hi == b) begin
                  base = 85;
                  diff = c - a;
               end else begin
                  base = 171;
                  diff = a - b;
               end
               hue = base + (43 * diff) / span;
               o.result_a = hue[7:0];
               o.result_b = sat[7:0];
            end
         end
      end else begin
         if (b == 0) begin
            o.result_a = c[7:0];
            o.result_b = c[7:0];
            o.result_c = c[7:0];
         end else begin
            region = a / 43;
            rem = ((a - region * 43) * 6) & 255;
            p = (c * (255 - b)) >> 8;
            q = (c * (255 - ((b * rem) >> 8))) >> 8;
            t = (c * (255 - ((b * (255 - rem)) >> 8))) >> 8;
            case (region)
               0: begin
                  o.result_a = c[7:0]; o.result_b = t[7:0]; o.result_c = p[7:0];
               end
               1: begin
                  o.result_a = q[7:0]; o.result_b = c[7:0]; o.result_c = p[7:0];
               end
               2: begin
                  o.result_a = p[7:0]; o.result_b = c[7:0]; o.result_c = t[7:0];
               end
               3: begin
                  o.result_a = p[7:0]; o.result_b = q[7:0]; o.result_c = c[7:0];
               end
               4: begin
                  o.result_a = t[7:0]; o.result_b = p[7:0]; o.result_c = c[7:0];
               end
               default: begin
                  o.result_a = c[7:0]; o.result_b = p[7:0]; o.result_c = q[7:0];
               end
            endcase
         end
      end
      return o;
   endfunction

   function automatic logic [7:0] random_channel();
      case ($urandom_range(0, 9))
         0: return 8'd0;
         1: return 8'd255;
         2: return 8'($urandom_range(0, 3));
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [7:0] got,
                              input logic [7:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("word %0d %s got %0d expected %0d",
                                   checked_count, name, got, want));
      end
   endtask

   // called at a falling edge, returns at a falling edge
   task automatic send_pixel(input logic [7:0] a, input logic [7:0] b,
                             input logic [7:0] c);
      int gap;
      req_word_type px;
      gap = idle_enable ? $urandom_range(0, 19) : 0;
      px.channel_a = a;
      px.channel_b = b;
      px.channel_c = c;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_word  <= px;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      expected_pixels.push_back(converted_pixel(active_direction, px));
      @(negedge clock);
   endtask

   task automatic drain_pipeline();
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (PIPE_STAGES) @(negedge clock);
   endtask

   task automatic set_direction(input logic mode);
      drain_pipeline();
      csr_write_enable <= 1'b1;
      csr_write_data   <= mode;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      active_direction = mode;
      @(negedge clock);
   endtask

   // relies on the reset direction, no register write yet
   task automatic test_forward_directed();
      send_pixel(8'd0,   8'd0,   8'd0);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd128, 8'd128, 8'd128);
      send_pixel(8'd255, 8'd0,   8'd0);
      send_pixel(8'd0,   8'd255, 8'd0);
      send_pixel(8'd0,   8'd0,   8'd255);
      send_pixel(8'd255, 8'd255, 8'd0);
      send_pixel(8'd0,   8'd255, 8'd255);
      send_pixel(8'd255, 8'd0,   8'd255);
      send_pixel(8'd255, 8'd0,   8'd10);
      send_pixel(8'd100, 8'd50,  8'd60);
      send_pixel(8'd1,   8'd0,   8'd0);
      send_pixel(8'd0,   8'd1,   8'd2);
   endtask

   task automatic test_reverse_directed();
      set_direction(DIR_HSV_TO_RGB);
      send_pixel(8'd0,   8'd0,   8'd200);
      send_pixel(8'd0,   8'd255, 8'd255);
      send_pixel(8'd42,  8'd255, 8'd255);
      send_pixel(8'd43,  8'd128, 8'd200);
      send_pixel(8'd100, 8'd200, 8'd150);
      send_pixel(8'd128, 8'd255, 8'd255);
      send_pixel(8'd172, 8'd90,  8'd255);
      send_pixel(8'd214, 8'd255, 8'd255);
      send_pixel(8'd215, 8'd255, 8'd255);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd30,  8'd1,   8'd0);
      send_pixel(8'd255, 8'd1,   8'd1);
   endtask

   task automatic test_random_pixels();
      logic [7:0] a, b, c;
      for (int phase = 0; phase < 6; phase++) begin
         set_direction((phase % 2 == 1) ? DIR_HSV_TO_RGB : DIR_RGB_TO_HSV);
         for (int n = 0; n < 150; n++) begin
            if (n % 50 == 0) idle_enable = ($urandom_range(0, 3) != 0);
            // let the pipeline run dry once in mid phase
            if (phase == 2 && n == 75) drain_pipeline();
            a = random_channel();
            b = random_channel();
            c = random_channel();
            // ties and greys
            case ($urandom_range(0, 7))
               0: b = a;
               1: c = a;
               2: begin
                  b = a;
                  c = a;
               end
               default: ;
            endcase
            send_pixel(a, b, c);
         end
      end
   endtask

   initial begin : rsp_stall_gen
      int hold;
      rsp_stall = 1'b0;
      forever begin
         hold = idle_enable ? $urandom_range(0, 19) : 0;
         repeat (hold) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
         end
         @(negedge clock);
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid || reset);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_pixels.size() == 0) begin
            report_mismatch("output word with no expected word pending");
         end else begin
            want_pixel = expected_pixels.pop_front();
            check_field("result_a", rsp_word.result_a, want_pixel.result_a);
            check_field("result_b", rsp_word.result_b, want_pixel.result_b);
            check_field("result_c", rsp_word.result_c, want_pixel.result_c);
         end
         checked_count++;
      end
   end

   initial begin
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data   = DIR_RGB_TO_HSV;
      req_valid        = 1'b0;
      req_word         = '0;
      active_direction = DIR_RGB_TO_HSV;
      idle_enable      = 1'b1;
      mismatch_count   = 0;
      checked_count    = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_forward_directed();
      test_reverse_directed();
      test_random_pixels();

      drain_pipeline();
      repeat (4 * PIPE_STAGES) @(posedge clock);
      if (mismatch_count == 0 && expected_pixels.size() == 0) begin
         $display("** rgb_hsv_color_convert_top: PASSED **");
      end else begin
         $display("** rgb_hsv_color_convert_top: FAILED **");
      end
      $finish;
   end

endmodule
